/* rtl/core/wsrq_pkg.sv */
// Shared types and constants for the work-stealing run queues.
// No dependencies; used by wsrq_ptrs and work_stealing_run_queues.
package wsrq_pkg;

	// Sizing (QUEUE_DEPTH must be a power of two)
	localparam int NUM_PROCS    = 8;
	localparam int QUEUE_DEPTH  = 256;
	localparam int TASK_ID_BITS = 16;

	// Field widths of the transfer payloads
	localparam int OPCODE_BITS = 1;
	localparam int PROC_BITS   = 3;
	localparam int TASK_BITS   = 16;
	localparam int STATUS_BITS = 3;

	// Derived widths
	localparam int PIDX_BITS  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int SLOT_BITS  = $clog2(QUEUE_DEPTH);
	localparam int PTR_BITS   = SLOT_BITS + 1;
	localparam int ADDR_BITS  = PIDX_BITS + SLOT_BITS;
	localparam int STORE_DEPTH = NUM_PROCS * QUEUE_DEPTH;

	typedef enum logic [OPCODE_BITS-1:0] {
		OP_PUT = 1'b0,
		OP_GET = 1'b1
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_ENQUEUED = 3'd0,
		ST_DROPPED  = 3'd1,
		ST_LOCAL    = 3'd2,
		ST_STOLEN   = 3'd3,
		ST_NONE     = 3'd4
	} status_t;

	typedef struct packed {
		op_t                  opcode;
		logic [PROC_BITS-1:0] proc_index;
		logic [TASK_BITS-1:0] task_id;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [TASK_BITS-1:0] task_out;
		logic [PROC_BITS-1:0] source_proc;
	} rsp_t;

	// Queue decision handed from the pointer file to the datapath
	typedef struct packed {
		status_t              status;
		logic                 rd;
		logic                 wr;
		logic [PIDX_BITS-1:0] q;
		logic [ADDR_BITS-1:0] addr;
	} dec_t;

endpackage

/* rtl/core/wsrq_ram.sv */
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module wsrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, or read into the output register (held otherwise)
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

/* rtl/core/wsrq_ptrs.sv */
// Head/tail pointer file with the full/empty checks and the steal scan.
// Depends on wsrq_pkg.
module wsrq_ptrs (
	input  logic          clk,
	input  logic          arst_n,
	input  wsrq_pkg::req_t req,
	input  logic          upd,
	output wsrq_pkg::dec_t dec
);

	logic [wsrq_pkg::PTR_BITS-1:0]  head_q [wsrq_pkg::NUM_PROCS];
	logic [wsrq_pkg::PTR_BITS-1:0]  tail_q [wsrq_pkg::NUM_PROCS];
	logic [wsrq_pkg::NUM_PROCS-1:0] empty;
	logic [wsrq_pkg::PIDX_BITS-1:0] pidx;
	logic [wsrq_pkg::PIDX_BITS-1:0] steal;
	logic [wsrq_pkg::PTR_BITS-1:0]  head_sel;
	logic [wsrq_pkg::PTR_BITS-1:0]  tail_sel;
	logic [wsrq_pkg::PTR_BITS-1:0]  fill;
	logic                           in_range;
	logic                           found;

	// per-ring empty flags
	always_comb begin
		for (int i = 0; i < wsrq_pkg::NUM_PROCS; i++) begin
			empty[i] = (head_q[i] == tail_q[i]);
		end
	end

	assign pidx     = wsrq_pkg::PIDX_BITS'(req.proc_index);
	assign in_range = (int'(req.proc_index) < wsrq_pkg::NUM_PROCS);

	// first non-empty ring other than the asker, lowest index first
	always_comb begin
		found = 1'b0;
		steal = '0;
		for (int i = 0; i < wsrq_pkg::NUM_PROCS; i++) begin
			if (!found && !empty[i] && (wsrq_pkg::PIDX_BITS'(i) != pidx)) begin
				found = 1'b1;
				steal = wsrq_pkg::PIDX_BITS'(i);
			end
		end
	end

	// pick the ring, then classify
	always_comb begin
		dec.q = pidx;
		if (req.opcode == wsrq_pkg::OP_GET && empty[pidx]) begin
			dec.q = steal;
		end
		head_sel = head_q[dec.q];
		tail_sel = tail_q[dec.q];
		fill     = tail_sel - head_sel;
		dec.rd     = 1'b0;
		dec.wr     = 1'b0;
		dec.status = wsrq_pkg::ST_NONE;
		unique case (req.opcode)
			wsrq_pkg::OP_PUT: begin
				if (in_range && fill != wsrq_pkg::PTR_BITS'(wsrq_pkg::QUEUE_DEPTH)) begin
					dec.wr     = 1'b1;
					dec.status = wsrq_pkg::ST_ENQUEUED;
				end else begin
					dec.status = wsrq_pkg::ST_DROPPED;
				end
			end
			wsrq_pkg::OP_GET: begin
				if (in_range && !empty[pidx]) begin
					dec.rd     = 1'b1;
					dec.status = wsrq_pkg::ST_LOCAL;
				end else if (in_range && found) begin
					dec.rd     = 1'b1;
					dec.status = wsrq_pkg::ST_STOLEN;
				end
			end
			default: dec.status = wsrq_pkg::ST_NONE;
		endcase
		dec.addr = {dec.q, dec.wr ? tail_sel[wsrq_pkg::SLOT_BITS-1:0]
		                          : head_sel[wsrq_pkg::SLOT_BITS-1:0]};
	end

	// pointer advance on each accepted transfer (wraps modulo twice the depth)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wsrq_pkg::NUM_PROCS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else if (upd) begin
			if (dec.wr) begin
				tail_q[dec.q] <= tail_sel + 1'b1;
			end
			if (dec.rd) begin
				head_q[dec.q] <= head_sel + 1'b1;
			end
		end
	end

endmodule

/* rtl/core/work_stealing_run_queues.sv */
// Top level of the work-stealing run queues: handshakes, task store, result register.
// Depends on wsrq_pkg, wsrq_ram and wsrq_ptrs.
//
// One bounded FIFO ring of task ids per processor, all held in a single task RAM.
// A put appends to the named ring or is dropped when the ring is full; a get pops
// the asker's ring, or else steals the head of the lowest-numbered other ring that
// holds work. Every request yields exactly one response. Each request first gets its
// decision and the single RAM access, then waits in stage 1 for the RAM read data. The
// request side stalls while a request is in flight, so a new request is taken only
// once the last has left stage 1; a finished response waits in the output register and
// does not block the next request. No initialization pass is needed after reset.
module work_stealing_run_queues (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  wsrq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output wsrq_pkg::rsp_t rsp
);

	wsrq_pkg::dec_t dec;
	logic           accept;
	logic           valid_s1;
	wsrq_pkg::status_t status_s1;
	logic           rd_s1;
	logic [wsrq_pkg::PIDX_BITS-1:0] src_s1;
	logic [wsrq_pkg::TASK_ID_BITS-1:0] rdata;
	logic           out_free;
	logic           rsp_valid_q;
	wsrq_pkg::rsp_t rsp_q;

	assign req_stall = valid_s1;
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	wsrq_ptrs u_ptrs (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.upd    (accept),
		.dec    (dec)
	);

	wsrq_ram #(
		.WIDTH (wsrq_pkg::TASK_ID_BITS),
		.DEPTH (wsrq_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.en    (accept && (dec.rd || dec.wr)),
		.we    (dec.wr),
		.addr  (dec.addr),
		.wdata (wsrq_pkg::TASK_ID_BITS'(req.task_id)),
		.rdata (rdata)
	);

	// stage 1: decision waits for RAM read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= dec.status;
			rd_s1     <= dec.rd;
			src_s1    <= dec.q;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (valid_s1 && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && out_free) begin
			rsp_q.status      <= status_s1;
			rsp_q.task_out    <= rd_s1 ? wsrq_pkg::TASK_BITS'(rdata) : '0;
			rsp_q.source_proc <= rd_s1 ? wsrq_pkg::PROC_BITS'(src_s1) : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted transfer did not reach stage 1");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rsp_valid && rsp_stall |=> valid_s1)
		else $error("stage 1 dropped while response was stalled");

	a_no_task_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == wsrq_pkg::ST_ENQUEUED ||
		              rsp.status == wsrq_pkg::ST_DROPPED ||
		              rsp.status == wsrq_pkg::ST_NONE)
		|-> rsp.task_out == '0 && rsp.source_proc == '0)
		else $error("task or source reported without a pop");

	a_read_only_on_get: assert property (@(posedge clk) disable iff (!arst_n)
		accept && dec.rd |-> req.opcode == wsrq_pkg::OP_GET && !dec.wr)
		else $error("store read issued for a put");

endmodule
